/* hw/rtl/hda_pkg.sv */
`timescale 1ns / 1ps

package hda_pkg;

  localparam int PRE_SHIFT = 24;
  localparam int TABLE_LEN = 24;
  localparam int ANG_W     = 28;
  localparam int ACC_W     = 31;
  localparam int HEAD_W    = 16;
  localparam int RND_W     = HEAD_W + 1;
  localparam int DROP_W    = 13;
  localparam int DEG_ONE   = 1 << 20;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic [ACC_W-1:0]        acc_t;

  // atan(2^-i) in units of 2^-20 degree
  localparam ang_t ATAN_TAB [TABLE_LEN] = '{
    28'sd47185920, 28'sd27855475, 28'sd14718068, 28'sd7471121,
    28'sd3750058,  28'sd1876857,  28'sd938658,   28'sd469357,
    28'sd234682,   28'sd117342,   28'sd58671,    28'sd29335,
    28'sd14668,    28'sd7334,     28'sd3667,     28'sd1833,
    28'sd917,      28'sd458,      28'sd229,      28'sd115,
    28'sd57,       28'sd29,       28'sd14,       28'sd7
  };

  // half an output lsb folded into each quadrant offset, plus one full turn
  // where z is added; q4 subtracts z from a single turn so the sum stays
  // below two turns and one wrap step is enough
  localparam acc_t RND_HALF = acc_t'(1 << (DROP_W - 1));
  localparam acc_t BASE_Q1  = acc_t'(360 * DEG_ONE) + RND_HALF;
  localparam acc_t BASE_Q23 = acc_t'(540 * DEG_ONE) + RND_HALF;
  localparam acc_t BASE_Q4  = acc_t'(360 * DEG_ONE) + RND_HALF;

  localparam logic [RND_W-1:0] HEADING_WRAP = RND_W'(46080);

  // quadrant codes, {x negative, y negative}
  localparam logic [1:0] QUAD_PP = 2'b00;
  localparam logic [1:0] QUAD_NP = 2'b10;
  localparam logic [1:0] QUAD_NN = 2'b11;
  localparam logic [1:0] QUAD_PN = 2'b01;

endpackage

/* hw/rtl/hda_in_if.sv */
`timescale 1ns / 1ps

interface hda_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

/* hw/rtl/hda_out_if.sv */
`timescale 1ns / 1ps

interface hda_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] heading;
  logic        zero_length;

  modport source (output valid, heading, zero_length, input ready);
  modport sink   (input valid, heading, zero_length, output ready);
endinterface

/* hw/rtl/heading_angle_2d.sv */
`timescale 1ns / 1ps

// channel  | dir | payload
// ---------+-----+--------------------------------------------
// pair     | in  | start_x, start_y, end_x, end_y (signed Q8.8)
// result   | out | heading (unsigned Q9.7 deg), zero_length
//
// one transaction per cycle unless the result stalls; data passes through
// the entry register, unrolled vectoring stages and the output register.
// rst clears the valid bits only; data registers are not reset.
// a stalled result freezes the whole pipeline; nothing is dropped or repeated.
module heading_angle_2d #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input logic       clk,
  input logic       rst,
  hda_in_if.sink    pair,
  hda_out_if.source result
);
  import hda_pkg::*;

  localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int DW   = COORD_WIDTH + 1;
  localparam int XW   = COORD_WIDTH + PRE_SHIFT + 3;

  logic                 en;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [DW-1:0]        ax;
  logic [DW-1:0]        ay;

  logic signed [XW-1:0] xr   [0:NSTG];
  logic signed [XW-1:0] yr   [0:NSTG];
  ang_t                 zr   [0:NSTG];
  logic                 vr   [0:NSTG];
  logic                 zlr  [0:NSTG];
  logic                 nxr  [0:NSTG];
  logic                 nyr  [0:NSTG];

  acc_t             base;
  acc_t             zext;
  acc_t             acc;
  logic [RND_W-1:0] rnd;
  logic [15:0]      heading_next;

  assign en         = !result.valid || result.ready;
  assign pair.ready = en;

  assign dx = $signed({pair.end_x[COORD_WIDTH-1], pair.end_x})
            - $signed({pair.start_x[COORD_WIDTH-1], pair.start_x});
  assign dy = $signed({pair.end_y[COORD_WIDTH-1], pair.end_y})
            - $signed({pair.start_y[COORD_WIDTH-1], pair.start_y});
  assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);

  // entry: fold into the first quadrant and scale up
  always_ff @(posedge clk) begin
    if (rst) begin
      vr[0] <= 1'b0;
    end else if (en) begin
      vr[0] <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr[0]  <= $signed({{(XW-DW-PRE_SHIFT){1'b0}}, ax, {PRE_SHIFT{1'b0}}});
      yr[0]  <= $signed({{(XW-DW-PRE_SHIFT){1'b0}}, ay, {PRE_SHIFT{1'b0}}});
      zr[0]  <= '0;
      zlr[0] <= (dx == '0) && (dy == '0);
      nxr[0] <= dx[DW-1];
      nyr[0] <= dy[DW-1];
    end
  end

  // vectoring stages, one micro-rotation each
  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic signed [XW-1:0] xsh;
    logic signed [XW-1:0] ysh;
    logic                 ypos;
    logic                 yneg;

    assign xsh  = xr[k] >>> k;
    assign ysh  = yr[k] >>> k;
    assign yneg = yr[k][XW-1];
    assign ypos = !yr[k][XW-1] && (yr[k] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k+1] <= 1'b0;
      end else if (en) begin
        vr[k+1] <= vr[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zlr[k+1] <= zlr[k];
        nxr[k+1] <= nxr[k];
        nyr[k+1] <= nyr[k];
        if (ypos) begin
          xr[k+1] <= xr[k] + ysh;
          yr[k+1] <= yr[k] - xsh;
          zr[k+1] <= zr[k] + ATAN_TAB[k];
        end else if (yneg) begin
          xr[k+1] <= xr[k] - ysh;
          yr[k+1] <= yr[k] + xsh;
          zr[k+1] <= zr[k] - ATAN_TAB[k];
        end else begin
          xr[k+1] <= xr[k];
          yr[k+1] <= yr[k];
          zr[k+1] <= zr[k];
        end
      end
    end
  end

  // unfold by quadrant, round to 1/128 degree, wrap at 360
  always_comb begin
    unique case ({nxr[NSTG], nyr[NSTG]})
      QUAD_PP: base = BASE_Q1;
      QUAD_NP: base = BASE_Q23;
      QUAD_NN: base = BASE_Q23;
      QUAD_PN: base = BASE_Q4;
      default: base = BASE_Q1;
    endcase
  end

  assign zext = {{(ACC_W-ANG_W){zr[NSTG][ANG_W-1]}}, zr[NSTG]};
  assign acc  = (nxr[NSTG] ^ nyr[NSTG]) ? base - zext : base + zext;
  assign rnd  = acc[DROP_W+RND_W-1:DROP_W];
  assign heading_next = (rnd >= HEADING_WRAP) ? HEAD_W'(rnd - HEADING_WRAP)
                                              : HEAD_W'(rnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= vr[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en && vr[NSTG]) begin
      result.heading     <= zlr[NSTG] ? '0 : heading_next;
      result.zero_length <= zlr[NSTG];
    end
  end

endmodule

/* hw/rtl/hda_check.sv */
`timescale 1ns / 1ps

module hda_check (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] heading,
  input logic        zero_length
);
  import hda_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(heading) && $stable(zero_length))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> heading < 16'(HEADING_WRAP))
    else $error("heading out of range");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_length |-> heading == '0)
    else $error("zero length with nonzero heading");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind heading_angle_2d hda_check u_hda_check (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (pair.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .heading     (result.heading),
  .zero_length (result.zero_length)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int COORD_WIDTH      = 16;
  localparam int CORDIC_STAGES    = 16;
  localparam int USED_STAGES      = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int LATENCY          = USED_STAGES + 2;
  localparam int ITEMS_PER_PHASE  = 400;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT      = 200000;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct {
    coord_t      sx;
    coord_t      sy;
    coord_t      ex;
    coord_t      ey;
    logic [15:0] heading;
    logic        zero_length;
  } heading_expect_t;

  class heading_checker;
    // atan(2^-i) in units of 2^-20 degree
    localparam longint ATAN_DEG [24] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
      938658, 469357, 234682, 117342, 58671, 29335,
      14668, 7334, 3667, 1833, 917, 458,
      229, 115, 57, 29, 14, 7
    };
    localparam longint ONE_DEG = longint'(1) << 20;

    heading_expect_t pending_headings[$];
    int              mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function automatic void compute_heading(input coord_t sx, sy, ex, ey,
                                            output logic [15:0] heading,
                                            output logic zero_length);
      longint dx, dy, x, y, z, xs, ys, acc;
      dx = longint'(ex) - longint'(sx);
      dy = longint'(ey) - longint'(sy);
      if (dx == 0 && dy == 0) begin
        heading = '0;
        zero_length = 1'b1;
        return;
      end
      // fold into the first quadrant, scale up before the vectoring stages
      x = (dx < 0 ? -dx : dx) * (longint'(1) << 24);
      y = (dy < 0 ? -dy : dy) * (longint'(1) << 24);
      z = 0;
      for (int i = 0; i < USED_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys;
          y -= xs;
          z += ATAN_DEG[i];
        end else if (y < 0) begin
          x -= ys;
          y += xs;
          z -= ATAN_DEG[i];
        end
      end
      if (dx >= 0 && dy >= 0)
        acc = z;
      else if (dx < 0 && dy >= 0)
        acc = 180 * ONE_DEG - z;
      else if (dx < 0)
        acc = 180 * ONE_DEG + z;
      else
        acc = 360 * ONE_DEG - z;
      acc += 360 * ONE_DEG;
      if (acc < 0)
        acc = 0;
      // round to 1/128 degree, 360 wraps to 0
      heading = 16'(((acc + 4096) >>> 13) % 46080);
      zero_length = 1'b0;
    endfunction

    function void note_pair(input coord_t sx, sy, ex, ey);
      heading_expect_t e;
      e.sx = sx;
      e.sy = sy;
      e.ex = ex;
      e.ey = ey;
      compute_heading(sx, sy, ex, ey, e.heading, e.zero_length);
      pending_headings.push_back(e);
    endfunction

    task check_result(input logic [15:0] heading, input logic zero_length);
      heading_expect_t e;
      if (pending_headings.size() == 0) begin
        report_mismatch($sformatf("unexpected result heading=%0d zero_length=%0b",
                                  heading, zero_length));
        return;
      end
      e = pending_headings.pop_front();
      if (heading !== e.heading || zero_length !== e.zero_length)
        report_mismatch($sformatf(
          "(%0d,%0d)->(%0d,%0d) heading=%0d zero_length=%0b, want %0d %0b",
          e.sx, e.sy, e.ex, e.ey, heading, zero_length, e.heading, e.zero_length));
    endtask

    function int outstanding();
      return pending_headings.size();
    endfunction

    task report_leftovers();
      while (pending_headings.size() != 0) begin
        heading_expect_t e;
        e = pending_headings.pop_front();
        report_mismatch($sformatf("no result for (%0d,%0d)->(%0d,%0d)",
                                  e.sx, e.sy, e.ex, e.ey));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   phase;
  logic long_hold;
  int   cycle_count = 0;

  heading_checker headings;

  hda_in_if #(.COORD_WIDTH(COORD_WIDTH)) pair_if ();
  hda_out_if result_if ();

  heading_angle_2d #(
    .COORD_WIDTH  (COORD_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .pair  (pair_if),
    .result(result_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver side: random stalls plus the long hold-off
  always @(negedge clk) begin
    result_if.ready <= !long_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    long_hold = 1'b0;
    wait (phase == 2);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_if.valid && result_if.ready)
        headings.check_result(result_if.heading, result_if.zero_length);
      if (pair_if.valid && pair_if.ready)
        headings.note_pair(pair_if.start_x, pair_if.start_y, pair_if.end_x, pair_if.end_y);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_pair(input coord_t sx, sy, ex, ey);
    while ($urandom_range(99) < tx_idle_pct) begin
      pair_if.valid <= 1'b0;
      @(negedge clk);
    end
    pair_if.valid   <= 1'b1;
    pair_if.start_x <= sx;
    pair_if.start_y <= sy;
    pair_if.end_x   <= ex;
    pair_if.end_y   <= ey;
    do @(posedge clk); while (!pair_if.ready);
    @(negedge clk);
  endtask

  function automatic coord_t pick_extreme();
    case ($urandom_range(4))
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      2: return coord_t'(0);
      3: return coord_t'(-1);
      default: return coord_t'(1);
    endcase
  endfunction

  task automatic send_random_pair();
    coord_t sx, sy, ex, ey;
    int     mag;
    sx = coord_t'($urandom);
    sy = coord_t'($urandom);
    ex = coord_t'($urandom);
    ey = coord_t'($urandom);
    case ($urandom_range(9))
      4, 5: begin
        // short vectors, wrapping in the field is fine
        ex = sx + coord_t'($urandom_range(16) - 8);
        ey = sy + coord_t'($urandom_range(16) - 8);
      end
      6: begin
        ex = sx;
        ey = sy;
      end
      7: begin
        if ($urandom_range(1))
          ex = sx;
        else
          ey = sy;
      end
      8: begin
        // near the diagonals
        mag = $urandom_range(16000);
        ex = sx + coord_t'($urandom_range(1) ? mag : -mag);
        ey = sy + coord_t'(($urandom_range(1) ? mag : -mag) + int'($urandom_range(2)) - 1);
      end
      9: begin
        sx = pick_extreme();
        sy = pick_extreme();
        ex = pick_extreme();
        ey = pick_extreme();
      end
      default: ;
    endcase
    send_pair(sx, sy, ex, ey);
  endtask

  initial begin
    headings = new();
    clk = 1'b0;
    rst = 1'b1;
    phase = 0;
    tx_idle_pct = 15;
    rx_idle_pct = 80;
    pair_if.valid   = 1'b0;
    pair_if.start_x = '0;
    pair_if.start_y = '0;
    pair_if.end_x   = '0;
    pair_if.end_y   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // coincident points
    send_pair(0, 0, 0, 0);
    send_pair(-32768, -32768, -32768, -32768);
    send_pair(32767, 32767, 32767, 32767);
    // axes and diagonals
    send_pair(0, 0, 256, 0);
    send_pair(0, 0, 0, 256);
    send_pair(0, 0, -256, 0);
    send_pair(0, 0, 0, -256);
    send_pair(0, 0, 256, 256);
    send_pair(0, 0, -256, 256);
    send_pair(0, 0, -256, -256);
    send_pair(0, 0, 256, -256);
    // full-range differences
    send_pair(-32768, -32768, 32767, 32767);
    send_pair(32767, 32767, -32768, -32768);
    send_pair(-32768, 0, 32767, 0);
    send_pair(32767, 0, -32768, 0);
    send_pair(0, 32767, 0, -32768);
    send_pair(32767, -32768, -32768, 32767);
    send_pair(-32768, 32767, 32767, -32768);
    // just below a full turn rounds up and wraps to 0
    send_pair(0, 0, 32767, -1);
    send_pair(0, 0, 32767, 1);
    send_pair(0, 0, -32768, -1);
    send_pair(0, 0, 1, 0);
    send_pair(0, 0, -1, -1);
    send_pair(1, 0, 0, 1);
    send_pair(100, -200, -100, 200);

    for (int p = 0; p < 3; p++) begin
      phase = p;
      case (p)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 80;
        end
        1: begin
          tx_idle_pct = 80;
          rx_idle_pct = 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_random_pair();
    end
    pair_if.valid <= 1'b0;

    while (headings.outstanding() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    headings.report_leftovers();
    if (headings.mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

/* heading_angle_2d.f */
hw/rtl/hda_pkg.sv
hw/rtl/hda_in_if.sv
hw/rtl/hda_out_if.sv
hw/rtl/heading_angle_2d.sv
hw/rtl/hda_check.sv
tb/testbench.sv
